// ===== src/pfst_pkg.sv =====
// shared types and constants of the planar flat span texturer
package pfst_pkg;

	typedef logic [1:0]  func_t;
	typedef logic [1:0]  cfg_idx_t;
	typedef logic [1:0]  detail_t;
	typedef logic [31:0] packed_t;

	localparam func_t FUNC_LOAD_TEXEL = 2'd0;
	localparam func_t FUNC_LOAD_SHADE = 2'd1;
	localparam func_t FUNC_DRAW       = 2'd2;

	localparam cfg_idx_t CFG_DETAIL   = 2'd0;
	localparam cfg_idx_t CFG_WINDOW_X = 2'd1;
	localparam cfg_idx_t CFG_WINDOW_Y = 2'd2;

	localparam detail_t DETAIL_HIGH   = 2'd0;
	localparam detail_t DETAIL_LOW    = 2'd2;

	localparam int TEXEL_AW   = 12;
	localparam int TEXELS     = 4096;
	localparam int CFG_DATA_W = 9;

	// texel index: row from bits 15..10, column from bits 31..26
	function automatic logic [TEXEL_AW-1:0] texel_of(input packed_t pos);
		texel_of = {pos[15:10], pos[31:26]};
	endfunction

endpackage

// ===== src/pfst_ram.sv =====
// generic single-write, single-read ram with registered read data
module pfst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== src/planar_flat_span_texturer.sv =====
// top level of the planar flat span texturer: span sequencer, texel and shade stores
//
//  channel   direction  handshake                word
//  item      in         item_valid / item_stall  load or draw command
//  pixel     out        pix_valid / pix_stall    one frame buffer byte write
//  cfg       in         cfg_we                   one register write
//
// loads are taken without leaving the idle state; a draw segment passes a
// setup state first when it starts a new span, then per pixel a texel read
// then a shade read through the two registered ram ports (texel read of the
// next pixel overlaps the hand-over of the current one)
// reset clears the sequencer and the span state; the stores are not cleared
// a stalled pixel holds its word; item_stall stays high until the segment ends
module planar_flat_span_texturer import pfst_pkg::*; #(
	parameter int NUM_SHADES  = 34,
	parameter int PLANE_BYTES = 16000,
	parameter int ROW_BYTES   = 80,
	parameter int MAX_SEGMENT = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// item channel
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [1:0]            func,
	input  logic                  first_segment,
	input  logic [13:0]           load_index,
	input  logic [7:0]            load_value,
	input  logic [8:0]            start_x,
	input  logic [7:0]            row_y,
	input  logic [6:0]            pixel_count,
	input  logic [5:0]            shade_select,
	input  logic [31:0]           x_frac,
	input  logic [31:0]           y_frac,
	input  logic [31:0]           x_step,
	input  logic [31:0]           y_step,
	// pixel channel
	output logic                  pix_valid,
	input  logic                  pix_stall,
	output logic [15:0]           dest_address,
	output logic [7:0]            pixel_value,
	output logic                  last_pixel
);

	localparam int SHADE_DEPTH = NUM_SHADES * 256;
	localparam int SHADE_AW    = $clog2(SHADE_DEPTH);
	localparam int CNT_W       = $clog2(MAX_SEGMENT + 1);

	localparam logic [13:0] ROW_BYTES14 = 14'(ROW_BYTES);
	localparam logic [15:0] PLANE_BASE1 = 16'(PLANE_BYTES);
	localparam logic [15:0] PLANE_BASE2 = 16'(2 * PLANE_BYTES);
	localparam logic [15:0] PLANE_BASE3 = 16'(3 * PLANE_BYTES);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_TEX   = 3'd2;
	localparam logic [2:0] ST_SHD   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]          state_q;

	// configuration registers
	detail_t             detail_q;
	logic [8:0]          window_x_q;
	logic [7:0]          window_y_q;

	// span state
	packed_t             pos_q;
	packed_t             step_q;
	logic [TEXEL_AW-1:0] pending_q;
	logic [1:0]          plane_q;
	logic [13:0]         byte_q;
	logic [5:0]          shade_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [10:0]         col_q;
	logic [9:0]          row_q;

	// pixel word being handed over
	logic [15:0]         dest_q;
	logic                last_q;

	logic                item_acc;
	logic                pix_acc;
	logic                issue;
	logic                draw_go;
	logic [CNT_W-1:0]    seg_cnt;
	logic [5:0]          shade_sat;
	logic [10:0]         col_d;
	logic [9:0]          row_d;
	packed_t             pos_d;
	logic [15:0]         plane_base;
	logic                texel_we;
	logic                shade_we;
	logic [7:0]          texel_rdata;
	logic [7:0]          shade_rdata;
	logic [SHADE_AW-1:0] shade_raddr;

	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign pix_valid  = (state_q == ST_OUT);
	assign pix_acc    = pix_valid && !pix_stall;

	// a pixel is issued from the texel state, or straight after the previous
	// pixel leaves when more remain
	assign issue = (state_q == ST_TEX) || (pix_acc && !last_q);

	// segment length, saturated
	assign seg_cnt = ({1'b0, pixel_count} > 8'(MAX_SEGMENT)) ? CNT_W'(MAX_SEGMENT)
	                                                         : CNT_W'(pixel_count);
	assign draw_go = item_acc && (func == FUNC_DRAW) && (pixel_count != 7'd0);

	assign shade_sat = ({1'b0, shade_select} >= 7'(NUM_SHADES)) ? 6'(NUM_SHADES - 1)
	                                                           : shade_select;

	// screen position of the span start, doubled per detail mode
	assign col_d = ((detail_q == DETAIL_HIGH) ? {2'b00, start_x} : {1'b0, start_x, 1'b0})
	             + {2'b00, window_x_q};
	assign row_d = ((detail_q >= DETAIL_LOW) ? {1'b0, row_y, 1'b0} : {2'b00, row_y})
	             + {2'b00, window_y_q};

	// x integer and fraction above y: the step carry runs from y into x
	assign pos_d = {x_frac[31:16], y_frac[31:16]};

	always_comb begin
		case (plane_q)
			2'd1:    plane_base = PLANE_BASE1;
			2'd2:    plane_base = PLANE_BASE2;
			2'd3:    plane_base = PLANE_BASE3;
			default: plane_base = 16'd0;
		endcase
	end

	assign texel_we = item_acc && (func == FUNC_LOAD_TEXEL)
	               && ({1'b0, load_index} < 15'(TEXELS));
	assign shade_we = item_acc && (func == FUNC_LOAD_SHADE)
	               && ({1'b0, load_index} < 15'(SHADE_DEPTH));

	assign shade_raddr = SHADE_AW'({shade_q, texel_rdata});

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detail_q   <= DETAIL_HIGH;
			window_x_q <= 9'd0;
			window_y_q <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DETAIL:   detail_q   <= cfg_data[1:0];
				CFG_WINDOW_X: window_x_q <= cfg_data[8:0];
				CFG_WINDOW_Y: window_y_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// sequencer and span state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			step_q    <= '0;
			pending_q <= '0;
			plane_q   <= 2'd0;
			byte_q    <= 14'd0;
			shade_q   <= 6'd0;
			cnt_q     <= '0;
			col_q     <= 11'd0;
			row_q     <= 10'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (draw_go) begin
						cnt_q <= seg_cnt;
						if (first_segment) begin
							pos_q     <= pos_d;
							step_q    <= {x_step[31:16], y_step[31:16]};
							shade_q   <= shade_sat;
							pending_q <= texel_of(pos_d);
							col_q     <= col_d;
							row_q     <= row_d;
							state_q   <= ST_SETUP;
						end else begin
							state_q <= ST_TEX;
						end
					end
				end
				ST_SETUP: begin
					// byte within plane wraps at 14 bits
					byte_q  <= 14'(row_q) * ROW_BYTES14 + 14'(col_q[10:2]);
					plane_q <= col_q[1:0];
					state_q <= ST_TEX;
				end
				ST_TEX: begin
					state_q <= ST_SHD;
				end
				ST_SHD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (pix_acc) begin
						state_q <= last_q ? ST_IDLE : ST_SHD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// texel read is launched with the old pending index; then step on
			if (issue) begin
				cnt_q     <= cnt_q - 1'b1;
				pending_q <= texel_of(pos_q);
				pos_q     <= pos_q + step_q;
				if (detail_q == DETAIL_HIGH) begin
					if (plane_q == 2'd3) begin
						plane_q <= 2'd0;
						byte_q  <= byte_q + 14'd1;
					end else begin
						plane_q <= plane_q + 2'd1;
					end
				end else begin
					if (plane_q == 2'd2) begin
						plane_q <= 2'd0;
						byte_q  <= byte_q + 14'd1;
					end else begin
						plane_q <= 2'd2;
					end
				end
			end
		end
	end

	// pixel word: address and end flag caught at issue
	always_ff @(posedge clk) begin
		if (issue) begin
			dest_q <= plane_base + {2'b00, byte_q};
			last_q <= (cnt_q == CNT_W'(1));
		end
	end

	assign dest_address = dest_q;
	assign last_pixel   = last_q;
	assign pixel_value  = shade_rdata;

	pfst_ram #(
		.WIDTH (8),
		.DEPTH (TEXELS)
	) u_texel_ram (
		.clk     (clk),
		.wr_en   (texel_we),
		.wr_addr (load_index[TEXEL_AW-1:0]),
		.wr_data (load_value),
		.rd_en   (issue),
		.rd_addr (pending_q),
		.rd_data (texel_rdata)
	);

	pfst_ram #(
		.WIDTH (8),
		.DEPTH (SHADE_DEPTH)
	) u_shade_ram (
		.clk     (clk),
		.wr_en   (shade_we),
		.wr_addr (load_index[SHADE_AW-1:0]),
		.wr_data (load_value),
		.rd_en   (state_q == ST_SHD),
		.rd_addr (shade_raddr),
		.rd_data (shade_rdata)
	);

	// remaining count never runs past the segment limit
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_SEGMENT))
		else $error("segment count out of range");

	// the last pixel word is the one issued with nothing left to draw
	a_last_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> (last_q == (cnt_q == '0)))
		else $error("end flag disagrees with remaining count");

	// once the last pixel leaves, the block takes items again
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_acc && last_q) |=> !item_stall)
		else $error("not idle after last pixel");

	// an accepted item never gives a pixel in the next cycle
	a_no_early_pix: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc |=> !pix_valid)
		else $error("pixel without texel and shade reads");

endmodule
